>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define NTC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define NTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define NTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ntc_pkg.sv
// Package with the character map, codes and result types of the compactor.
`timescale 1ns / 1ps

package ntc_pkg;

  localparam logic [7:0] CharTerm       = 8'd0;
  localparam logic [7:0] CharNewline    = 8'd10;
  localparam logic [7:0] CharMarker     = 8'd255;
  localparam logic [7:0] FirstPrintable = 8'd32;
  localparam int unsigned MapSize       = 95;
  localparam logic [7:0] LastPrintable  = 8'(32 + MapSize - 1);

  localparam logic [2:0] RowPlain    = 3'd0;
  localparam logic [2:0] RowDouble   = 3'd6;
  localparam logic [3:0] EscBase     = 4'd10;
  localparam logic [3:0] EscDouble   = 4'd15;
  localparam logic [3:0] IdxNewline  = 4'd2;
  localparam logic [3:0] IdxMarker   = 4'd7;
  localparam logic [3:0] NibZero     = 4'd0;

  // code = row * 16 + index, for characters 32 to 126
  localparam logic [7:0] CharMap [MapSize] = '{
    8'd1,   8'd60,  8'd61,  8'd62,  8'd102, 8'd101, 8'd65,  8'd66,
    8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd74,
    8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,
    8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,
    8'd63,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd40,
    8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,
    8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd58,  8'd59,  8'd91,  8'd92,  8'd93,  8'd94,  8'd97,
    8'd96,  8'd3,   8'd16,  8'd17,  8'd18,  8'd4,   8'd19,  8'd20,
    8'd5,   8'd6,   8'd21,  8'd22,  8'd23,  8'd24,  8'd7,   8'd8,
    8'd25,  8'd26,  8'd27,  8'd9,   8'd10,  8'd28,  8'd29,  8'd30,
    8'd31,  8'd32,  8'd33,  8'd98,  8'd99,  8'd100, 8'd64
  };

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       end_of_string;
    logic       last_of_input;
  } ntc_res_t;

  // Everything one character produces, plus the pending nibble it leaves.
  typedef struct packed {
    ntc_res_t   res0;
    ntc_res_t   res1;
    logic       two;
    logic [3:0] pend_nib;
    logic       pend_vld;
  } ntc_enc_t;

endpackage

>>> sv/ntc_char_if.sv
// Character input channel: valid, ready and one text character.
`timescale 1ns / 1ps

interface ntc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

>>> sv/ntc_res_if.sv
// Result output channel: valid, ready and one result item.
`timescale 1ns / 1ps

interface ntc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       byte_valid;
  logic       bad_char;
  logic       end_of_string;
  logic       last_of_input;

  modport source (output valid, output packed_byte, output byte_valid, output bad_char,
                  output end_of_string, output last_of_input, input ready);
  modport sink   (input valid, input packed_byte, input byte_valid, input bad_char,
                  input end_of_string, input last_of_input, output ready);
endinterface

>>> sv/nibble_text_compactor_top.sv
// Top level of the nibble text compactor: input register, encoder and result buffer.
//
//  channel  | modport | payload                                    | per request
//  ---------+---------+--------------------------------------------+-------------
//  char_i   | sink    | char_in                                    | one character
//  res_o    | source  | packed_byte, byte_valid, bad_char,         | one result
//           |         | end_of_string, last_of_input               |
//
// A character is registered, encoded combinationally and its one or two results land
// in a two-entry result buffer; the output port sends one result per cycle while
// res_o.ready is high. Sustained rate: one character per cycle when each gives one
// result and res_o is not stalled; after a two-byte character the next one waits for
// its second result to leave the single result port. Reset clears the input valid
// flag, the buffer count and the pending nibble. A stalled output holds the buffer;
// the input register takes a character while empty or while its character moves on.
`timescale 1ns / 1ps

module nibble_text_compactor_top
  import ntc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ntc_char_if.sink char_i,
  ntc_res_if.source res_o
);

  logic       item_vld_q, item_vld_d;
  logic [7:0] char_q;
  logic [3:0] pend_nib_q;
  logic       pend_vld_q;
  logic [1:0] buf_cnt_q, buf_cnt_d;
  ntc_res_t   slot0_q, slot0_d;
  ntc_res_t   slot1_q, slot1_d;
  ntc_enc_t   enc;
  logic       out_fire;
  logic       buf_free;
  logic       move;
  logic       in_fire;

  ntc_encoder u_encoder (
    .char_i     (char_q),
    .pend_nib_i (pend_nib_q),
    .pend_vld_i (pend_vld_q),
    .enc_o      (enc)
  );

  // Handshake decisions
  assign out_fire = res_o.valid && res_o.ready;
  assign buf_free = (buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && out_fire);
  assign move     = item_vld_q && buf_free;
  assign char_i.ready = !item_vld_q || move;
  assign in_fire  = char_i.valid && char_i.ready;

  // Input register
  always_comb begin
    item_vld_d = item_vld_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
    end else if (move) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_i.char_in;
    end
  end

  // Advance the pending nibble when a character is encoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_nib_q <= NibZero;
      pend_vld_q <= 1'b0;
    end else if (move) begin
      pend_nib_q <= enc.pend_nib;
      pend_vld_q <= enc.pend_vld;
    end
  end

  // Result buffer: load on a free buffer, shift down after the head is sent
  always_comb begin
    buf_cnt_d = buf_cnt_q;
    slot0_d   = slot0_q;
    slot1_d   = slot1_q;
    if (move) begin
      slot0_d   = enc.res0;
      slot1_d   = enc.res1;
      buf_cnt_d = enc.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      slot0_d   = slot1_q;
      buf_cnt_d = buf_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= 2'd0;
    end else begin
      buf_cnt_q <= buf_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // Drive the result port from the buffer head
  assign res_o.valid         = (buf_cnt_q != 2'd0);
  assign res_o.packed_byte   = slot0_q.packed_byte;
  assign res_o.byte_valid    = slot0_q.byte_valid;
  assign res_o.bad_char      = slot0_q.bad_char;
  assign res_o.end_of_string = slot0_q.end_of_string;
  assign res_o.last_of_input = slot0_q.last_of_input;

endmodule

>>> sv/ntc_encoder.sv
// Character encoder: map lookup, nibble sequence and byte packing for one character.
`timescale 1ns / 1ps

module ntc_encoder
  import ntc_pkg::*;
(
  input  logic [7:0] char_i,
  input  logic [3:0] pend_nib_i,
  input  logic       pend_vld_i,
  output ntc_enc_t   enc_o
);

  logic [7:0]      map_ofs;
  logic [7:0]      code;
  logic [2:0]      row;
  logic [3:0]      idx;
  logic            known;
  logic            eos;
  logic [3:0]      nibs [3];
  logic [1:0]      nn;
  logic [1:0]      cnt;
  logic [3:0]      pn;
  logic            pv;
  ntc_res_t        res [2];
  ntc_res_t        emit;

  always_comb begin
    map_ofs = char_i - FirstPrintable;
    code    = CharMap[map_ofs[6:0]];
    row     = RowPlain;
    idx     = NibZero;
    known   = 1'b1;
    eos     = (char_i == CharTerm);

    // Look up row and index
    if (char_i == CharTerm) begin
      row = RowPlain;
      idx = NibZero;
    end else if (char_i == CharNewline) begin
      row = RowPlain;
      idx = IdxNewline;
    end else if (char_i == CharMarker) begin
      row = RowDouble;
      idx = IdxMarker;
    end else if (char_i >= FirstPrintable && char_i <= LastPrintable) begin
      row = code[6:4];
      idx = code[3:0];
    end else begin
      known = 1'b0;
    end

    // Build the nibble sequence
    nibs[0] = idx;
    nibs[1] = idx;
    nibs[2] = idx;
    nn      = 2'd1;
    if (row == RowDouble) begin
      nibs[0] = EscDouble;
      nibs[1] = EscDouble;
      nn      = 2'd3;
    end else if (row != RowPlain) begin
      nibs[0] = EscBase + {1'b0, row};
      nn      = 2'd2;
    end

    // Pack nibbles, high half first
    pn     = pend_nib_i;
    pv     = pend_vld_i;
    cnt    = 2'd0;
    res[0] = '0;
    res[1] = '0;
    for (int i = 0; i < 3; i++) begin
      emit = '0;
      if (2'(i) < nn) begin
        if (pv) begin
          emit.packed_byte   = {pn, nibs[i]};
          emit.byte_valid    = 1'b1;
          emit.end_of_string = eos && (2'(i) == nn - 2'd1);
          res[cnt[0]]        = emit;
          cnt                = cnt + 2'd1;
          pv                 = 1'b0;
          pn                 = NibZero;
        end else if (nibs[i] == NibZero) begin
          emit.byte_valid    = 1'b1;
          emit.end_of_string = eos && (2'(i) == nn - 2'd1);
          res[cnt[0]]        = emit;
          cnt                = cnt + 2'd1;
        end else begin
          pn = nibs[i];
          pv = 1'b1;
        end
      end
    end

    // Drop unmapped characters and leave the state alone
    if (!known) begin
      res[0]          = '0;
      res[0].bad_char = 1'b1;
      res[1]          = '0;
      cnt             = 2'd1;
      pn              = pend_nib_i;
      pv              = pend_vld_i;
    end

    // Mark the final result of this character
    if (cnt == 2'd2) begin
      res[1].last_of_input = 1'b1;
    end else begin
      res[0].last_of_input = 1'b1;
    end

    enc_o.res0     = res[0];
    enc_o.res1     = res[1];
    enc_o.two      = (cnt == 2'd2);
    enc_o.pend_nib = pn;
    enc_o.pend_vld = pv;
  end

endmodule

>>> sv/ntc_checker.sv
// Port checker for the nibble text compactor and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] packed_byte_i,
  input logic       byte_valid_i,
  input logic       bad_char_i,
  input logic       end_of_string_i,
  input logic       last_of_input_i
);

  logic [11:0] out_word;
  assign out_word = {packed_byte_i, byte_valid_i, bad_char_i, end_of_string_i,
                     last_of_input_i};

  // A stalled result holds its payload
  `NTC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word), "stalled result changed")

  // A dropped character gives an empty, final result
  `NTC_ASSERT_IMPLY(a_bad_empty, clk_i, rst_ni, out_valid_i && bad_char_i, !byte_valid_i && !end_of_string_i && last_of_input_i && packed_byte_i == 8'd0, "bad character result not empty")

  // The terminator closes on a byte with a zero low nibble, as the last result
  `NTC_ASSERT_IMPLY(a_eos_byte, clk_i, rst_ni, out_valid_i && end_of_string_i, byte_valid_i && last_of_input_i && packed_byte_i[3:0] == 4'd0, "terminator byte malformed")

  // A result without a byte carries zero data
  `NTC_ASSERT_ALWAYS(a_empty_zero, clk_i, rst_ni, !out_valid_i || byte_valid_i || packed_byte_i == 8'd0, "empty result carries data")

endmodule

bind nibble_text_compactor_top ntc_checker u_ntc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .packed_byte_i   (res_o.packed_byte),
  .byte_valid_i    (res_o.byte_valid),
  .bad_char_i      (res_o.bad_char),
  .end_of_string_i (res_o.end_of_string),
  .last_of_input_i (res_o.last_of_input)
);
